[hw/rtl/assert_macros.svh]
// Assertion macros shared by the setpoint generator RTL.
// Clocked, reset-qualified concurrent assertions that report through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, off while reset is low.
`define TPAS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression that must never be true outside reset.
`define TPAS_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

[hw/rtl/tpas_pkg.sv]
// Shared types, widths and constants for the triangular profile setpoint generator.
// No dependencies; used by tpas_engine and the top level.
`timescale 1ns / 1ps

package tpas_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 16;

    localparam int ANGLE_W   = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 72;

    // engine datapath: signed argument and working registers
    localparam int ARG_W      = 36;
    localparam int DVD_W      = 35;          // 4*|d| needs 35 bits
    localparam int TICK_W     = 18;          // isqrt of a 35-bit value
    localparam int ELAP_W     = TICK_W + 1;
    localparam int SQRT_STEPS = 18;
    localparam int CNT_W      = 6;

    // pi and 2*pi in Q2.30, rounded at elaboration to the angle format
    localparam logic [63:0] PI_Q30     = 64'd3373259426;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 8'd1;

    localparam logic [CFG_W-1:0] ACCEL_RST = 16'd16;
    localparam logic [CFG_W-1:0] TOL_RST   = 16'd655;

    typedef enum logic [1:0] {
        OP_DIV,
        OP_SQRT,
        OP_WRAP
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_eng_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_stat;

    function automatic logic [63:0] round_q30(input logic [63:0] q30, input int frac);
        round_q30 = (q30 + (64'd1 << (29 - frac))) >> (30 - frac);
    endfunction

endpackage

[hw/rtl/tpas_engine.sv]
// Iterative arithmetic engine: restoring divide, integer square root and angle wrap.
// One shared subtract/compare unit steps one bit per cycle. Depends on tpas_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpas_engine #(
    parameter int ANGLE_FRAC_BITS = tpas_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tpas_pkg::t_eng_req                   i_req,
    input  logic signed [tpas_pkg::ARG_W-1:0]    i_arg,
    input  logic        [tpas_pkg::CFG_W-1:0]    i_divisor,
    output tpas_pkg::t_eng_stat                  o_stat,
    output logic        [tpas_pkg::ARG_W-1:0]    o_result
);
    import tpas_pkg::*;

    localparam logic [ARG_W-1:0] PI_FX     = ARG_W'(round_q30(PI_Q30, ANGLE_FRAC_BITS));
    localparam logic [ARG_W-1:0] TWO_PI_FX = ARG_W'(round_q30(TWO_PI_Q30, ANGLE_FRAC_BITS));
    // |x| <= 2^32, so the modulus shifted this far covers the whole range
    localparam int               WRAP_SHIFT = 33 - $clog2(TWO_PI_FX);
    localparam logic [ARG_W-1:0] MOD_TOP    = TWO_PI_FX << WRAP_SHIFT;
    localparam logic [ARG_W-1:0] SQRT_TOP   = ARG_W'(1) << (2 * (SQRT_STEPS - 1));

    logic             r_busy;
    logic             r_fix;
    logic             r_done;
    t_op              r_op;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [ARG_W-1:0] r_acc;
    logic [ARG_W-1:0] r_res;
    logic [ARG_W-1:0] r_opb;

    logic [ARG_W-1:0] arg_u;
    logic [ARG_W-1:0] mag;
    logic [ARG_W-1:0] sub_a;
    logic [ARG_W-1:0] sub_b;
    logic [ARG_W:0]   diff;
    logic             ge;
    logic [ARG_W-1:0] wrap_val;

    assign arg_u = i_arg;
    assign mag   = arg_u[ARG_W-1] ? (~arg_u + ARG_W'(1)) : arg_u;

    // shared subtract/compare unit
    always_comb begin
        case (r_op)
            OP_DIV: begin
                sub_a = {{(ARG_W-CFG_W-1){1'b0}}, r_acc[CFG_W-1:0], r_res[DVD_W-1]};
                sub_b = r_opb;
            end
            OP_SQRT: begin
                sub_a = r_acc;
                sub_b = r_res | r_opb;
            end
            default: begin
                sub_a = r_acc;
                sub_b = r_opb;
            end
        endcase
    end

    assign diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign ge   = ~diff[ARG_W];

    // remainder is in [0, 2pi): restore sign, then fold into (-pi, pi]
    always_comb begin
        if (r_neg) begin
            wrap_val = (r_acc >= PI_FX) ? (TWO_PI_FX - r_acc) : (~r_acc + ARG_W'(1));
        end else begin
            wrap_val = (r_acc > PI_FX) ? (r_acc - TWO_PI_FX) : r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_DIV;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                case (i_req.op)
                    OP_DIV:  r_cnt <= CNT_W'(DVD_W - 1);
                    OP_SQRT: r_cnt <= CNT_W'(SQRT_STEPS - 1);
                    default: r_cnt <= CNT_W'(WRAP_SHIFT);
                endcase
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    if (r_op == OP_WRAP) begin
                        r_fix <= 1'b1;
                    end else begin
                        r_done <= 1'b1;
                    end
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= arg_u[ARG_W-1];
            case (i_req.op)
                OP_DIV: begin
                    r_acc <= '0;
                    r_res <= mag << 2;
                    r_opb <= ARG_W'(i_divisor);
                end
                OP_SQRT: begin
                    r_acc <= mag;
                    r_res <= '0;
                    r_opb <= SQRT_TOP;
                end
                default: begin
                    r_acc <= mag;
                    r_res <= '0;
                    r_opb <= MOD_TOP;
                end
            endcase
        end else if (r_busy) begin
            case (r_op)
                OP_DIV: begin
                    r_acc <= ge ? diff[ARG_W-1:0] : sub_a;
                    r_res <= {r_res[ARG_W-2:0], ge};
                end
                OP_SQRT: begin
                    if (ge) begin
                        r_acc <= diff[ARG_W-1:0];
                    end
                    r_res <= (r_res >> 1) | (ge ? r_opb : '0);
                    r_opb <= r_opb >> 2;
                end
                default: begin
                    if (ge) begin
                        r_acc <= diff[ARG_W-1:0];
                    end
                    r_opb <= r_opb >> 1;
                end
            endcase
        end else if (r_fix) begin
            r_res <= wrap_val;
        end
    end

    assign o_stat.busy = r_busy | r_fix;
    assign o_stat.done = r_done;
    // quotient sits in the low bits; the top bit holds shifted-out dividend
    assign o_result    = (r_op == OP_DIV) ? {{(ARG_W-DVD_W){1'b0}}, r_res[DVD_W-1:0]} : r_res;

    `TPAS_ASSERT(a_done_pulse, i_clk, i_rst_n, r_done |=> !r_done, "engine done held two cycles")
    `TPAS_NEVER(a_no_restart, i_clk, i_rst_n, i_req.start && (r_busy || r_fix), "engine restarted while busy")
    `TPAS_ASSERT(a_fix_wrap, i_clk, i_rst_n, r_fix |-> (r_op == OP_WRAP), "wrap fixup outside wrap op")

endmodule

[hw/rtl/triangular_profile_angle_setpoint.sv]
// Triangular velocity profile setpoint generator for one rotary axis (Q15.16 radians).
// Top level: stream ports, config registers, profile state, sequencer. Uses tpas_pkg, tpas_engine.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One item in, one result out. A tick item (tuser 0) steps the profile: velocity
// ramps up by accel_per_tick for the first half of the move, down for the second,
// then the aim snaps to the target; aim is wrapped into (-pi, pi]. A goto item
// (tuser 1) restarts the profile from the given position and computes the move
// length isqrt(4*|target - position| / accel) in ticks. Each result carries aim,
// velocity, a moving flag and an arrived flag (|wrapped target - position| below
// arrive_tolerance). The block takes one item at a time; all arithmetic runs on
// one shared subtractor, one quotient bit, root bit or modulus step per cycle.
// With 16 fraction bits, a tick runs two angle wraps of 15 steps each while the
// profile runs and one wrap once the move has ended, and a goto runs one wrap, a
// 35-step divide and an 18-step root; the next item is not taken while a finished
// result cannot leave because the output register stays full.
// A finished result waits in an output register while the next item is taken.
// Config writes are taken at any time, one per cycle.
module triangular_profile_angle_setpoint #(
    parameter int ANGLE_FRAC_BITS = tpas_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [31:0] target_angle, [63:32] position
    input  logic [tpas_pkg::S_DATA_W-1:0]       i_s_axis_tdata,
    // [0] kind
    input  logic [0:0]                          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [31:0] aim_angle, [63:32] velocity, [64] moving, [65] at_target, [71:66] zero
    output logic [tpas_pkg::M_DATA_W-1:0]       o_m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tpas_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tpas_pkg::CFG_W-1:0]          i_cfg_data
);
    import tpas_pkg::*;

    localparam int               EXT_W    = ARG_W - ANGLE_W;
    localparam logic [TICK_W-1:0] TICK_MAX = TICK_W'(1) << (TICK_W - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR_GO,
        S_ERR_WAIT,
        S_AIM_GO,
        S_AIM_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_EMIT
    } t_state;

    t_state                    r_state;
    logic [CFG_W-1:0]          r_accel;
    logic [CFG_W-1:0]          r_tol;
    logic signed [ANGLE_W-1:0] r_aim;
    logic signed [ANGLE_W-1:0] r_speed;
    logic signed [ANGLE_W-1:0] r_goal;
    logic [ELAP_W-1:0]         r_elapsed;
    logic [TICK_W-1:0]         r_move_ticks;
    logic                      r_dir;
    logic                      r_kind;
    logic                      r_run;
    logic                      r_near;
    logic signed [ARG_W-1:0]   r_arg;
    logic                      r_m_valid;
    logic [ANGLE_W-1:0]        r_m_aim;
    logic [ANGLE_W-1:0]        r_m_speed;
    logic                      r_m_run;
    logic                      r_m_near;

    t_eng_req                  eng_req;
    t_eng_stat                 eng_stat;
    logic [ARG_W-1:0]          eng_result;

    logic                      in_fire;
    logic                      in_kind;
    logic signed [ANGLE_W-1:0] in_tgt;
    logic signed [ANGLE_W-1:0] in_pos;
    logic [CFG_W-1:0]          acc_eff;
    logic                      ph_acc;
    logic                      ph_dec;
    logic [ANGLE_W-1:0]        speed_step;
    logic signed [ANGLE_W-1:0] goal_sel;
    logic signed [ARG_W-1:0]   err_arg;
    logic signed [ARG_W-1:0]   aim_arg;
    logic [ANGLE_W-1:0]        err_val;
    logic [ANGLE_W-1:0]        err_abs;
    logic                      near;
    logic                      emit_fire;
    logic                      eng_wait;

    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;
    assign in_kind = i_s_axis_tuser[0];
    assign in_tgt  = i_s_axis_tdata[ANGLE_W-1:0];
    assign in_pos  = i_s_axis_tdata[2*ANGLE_W-1:ANGLE_W];

    assign acc_eff = (r_accel == '0) ? CFG_W'(1) : r_accel;

    // accelerate while 2*elapsed < N, decelerate while elapsed < N
    assign ph_acc = {1'b0, r_elapsed, 1'b0} < {3'b000, r_move_ticks};
    assign ph_dec = r_elapsed < {1'b0, r_move_ticks};

    assign speed_step = (ph_acc ^ r_dir) ? (r_speed + {{(ANGLE_W-CFG_W){1'b0}}, acc_eff})
                                         : (r_speed - {{(ANGLE_W-CFG_W){1'b0}}, acc_eff});

    assign goal_sel = in_kind ? in_tgt : r_goal;
    assign err_arg  = {{EXT_W{goal_sel[ANGLE_W-1]}}, goal_sel}
                    - {{EXT_W{in_pos[ANGLE_W-1]}}, in_pos};
    assign aim_arg  = {{EXT_W{r_aim[ANGLE_W-1]}}, r_aim}
                    + {{EXT_W{r_speed[ANGLE_W-1]}}, r_speed};

    // wrapped error is within (-pi, pi], so the negate cannot overflow
    assign err_val = eng_result[ANGLE_W-1:0];
    assign err_abs = err_val[ANGLE_W-1] ? (~err_val + ANGLE_W'(1)) : err_val;
    assign near    = err_abs < {{(ANGLE_W-CFG_W){1'b0}}, r_tol};

    // result register frees up in the same cycle its item is taken
    assign emit_fire = (r_state == S_EMIT) && (!r_m_valid || i_m_axis_tready);
    assign eng_wait  = r_state inside {S_ERR_WAIT, S_AIM_WAIT, S_DIV_WAIT, S_SQRT_WAIT};

    always_comb begin
        eng_req.start = 1'b0;
        eng_req.op    = OP_WRAP;
        case (r_state)
            S_ERR_GO, S_AIM_GO: eng_req.start = 1'b1;
            S_DIV_GO: begin
                eng_req.start = 1'b1;
                eng_req.op    = OP_DIV;
            end
            S_SQRT_GO: begin
                eng_req.start = 1'b1;
                eng_req.op    = OP_SQRT;
            end
            default: eng_req.start = 1'b0;
        endcase
    end

    tpas_engine #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (eng_req),
        .i_arg     (r_arg),
        .i_divisor (acc_eff),
        .o_stat    (eng_stat),
        .o_result  (eng_result)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{(M_DATA_W-2*ANGLE_W-2){1'b0}}, r_m_near, r_m_run,
                              r_m_speed, r_m_aim};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_accel      <= ACCEL_RST;
            r_tol        <= TOL_RST;
            r_aim        <= '0;
            r_speed      <= '0;
            r_goal       <= '0;
            r_elapsed    <= '0;
            r_move_ticks <= '0;
            r_dir        <= 1'b0;
            r_kind       <= 1'b0;
            r_run        <= 1'b0;
            r_near       <= 1'b0;
            r_arg        <= '0;
            r_m_valid    <= 1'b0;
            r_m_aim      <= '0;
            r_m_speed    <= '0;
            r_m_run      <= 1'b0;
            r_m_near     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ACCEL: r_accel <= i_cfg_data;
                    CFG_TOL:   r_tol   <= i_cfg_data;
                    default:   r_accel <= r_accel;
                endcase
            end

            if (emit_fire) begin
                r_m_valid <= 1'b1;
                r_m_aim   <= r_aim;
                r_m_speed <= r_speed;
                r_m_run   <= r_run;
                r_m_near  <= r_near;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_kind  <= in_kind;
                        r_arg   <= err_arg;
                        r_state <= S_ERR_GO;
                        if (in_kind) begin
                            r_aim     <= in_pos;
                            r_speed   <= '0;
                            r_elapsed <= '0;
                            r_dir     <= err_arg[ARG_W-1];
                            r_goal    <= in_tgt;
                            r_run     <= 1'b1;
                        end else begin
                            r_run <= ph_dec;
                            if (ph_dec) begin
                                r_speed <= speed_step;
                            end else begin
                                r_speed <= '0;
                                r_aim   <= r_goal;
                            end
                            // saturates well above any move length
                            if (r_elapsed != '1) begin
                                r_elapsed <= r_elapsed + ELAP_W'(1);
                            end
                        end
                    end
                end
                S_ERR_GO:  r_state <= S_ERR_WAIT;
                S_ERR_WAIT: begin
                    if (eng_stat.done) begin
                        r_near <= near;
                        if (r_kind) begin
                            r_state <= S_DIV_GO;
                        end else if (r_run) begin
                            r_arg   <= aim_arg;
                            r_state <= S_AIM_GO;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_AIM_GO:  r_state <= S_AIM_WAIT;
                S_AIM_WAIT: begin
                    if (eng_stat.done) begin
                        r_aim   <= err_val;
                        r_state <= S_EMIT;
                    end
                end
                S_DIV_GO:  r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (eng_stat.done) begin
                        r_arg   <= eng_result;
                        r_state <= S_SQRT_GO;
                    end
                end
                S_SQRT_GO: r_state <= S_SQRT_WAIT;
                S_SQRT_WAIT: begin
                    if (eng_stat.done) begin
                        r_move_ticks <= eng_result[TICK_W-1:0];
                        r_state      <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TPAS_ASSERT(a_one_item, i_clk, i_rst_n, in_fire |=> !o_s_axis_tready, "item taken while busy")
    `TPAS_ASSERT(a_done_wait, i_clk, i_rst_n, eng_stat.done |-> eng_wait, "engine done outside wait")
    `TPAS_ASSERT(a_ticks_max, i_clk, i_rst_n, r_move_ticks <= TICK_MAX, "move length out of range")

endmodule

[test/tb_top.sv]
// Self-checking bench for triangular_profile_angle_setpoint: goto/tick items in, setpoints out.
// Depends on tpas_pkg for register indexes and port widths; predicts every result internally.
`timescale 1ns / 1ps

module tb_top;
    import tpas_pkg::*;

    localparam int FRAC         = 16;
    localparam int IDLE_PCT     = 19;
    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_AT      = 260;
    localparam int HOLD_CYCLES  = 600;
    localparam int CALM_LO      = 330;
    localparam int CALM_HI      = 420;

    localparam longint PI_FX =
        longint'((64'd3373259426 + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
    localparam longint TWO_PI_FX =
        longint'((64'd6746518852 + (64'd1 << (29 - FRAC))) >> (30 - FRAC));

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_GOTO = 1'b1;

    // indexes past the register file, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hFF;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] tgt;
        logic signed [31:0] pos;
    } axis_item_t;

    typedef struct packed {
        logic [31:0] aim;
        logic [31:0] vel;
        logic        moving;
        logic        at_target;
    } setpoint_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  s_valid = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;
    wire                   s_ready;
    wire                   m_valid;
    wire  [M_DATA_W-1:0]   m_tdata;
    wire                   cfg_ready;

    triangular_profile_angle_setpoint dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the block's registers and profile state
    logic [15:0]        accel_reg = ACCEL_RST;
    logic [15:0]        tol_reg   = TOL_RST;
    logic signed [31:0] aim_q     = '0;
    logic signed [31:0] speed_q   = '0;
    logic signed [31:0] goal_q    = '0;
    logic [31:0]        elapsed_q = '0;
    logic [31:0]        ticks_q   = '0;
    logic               backward_q = 1'b0;

    axis_item_t pending_items[$];
    setpoint_t  expected_setpoints[$];
    axis_item_t next_item;
    setpoint_t  want;

    int items_taken  = 0;
    int results_seen = 0;
    int errors       = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int cycles       = 0;

    function automatic logic signed [31:0] wrap_pi(input longint x);
        longint r;
        r = x % TWO_PI_FX;
        if (r > PI_FX)
            r -= TWO_PI_FX;
        else if (r <= -PI_FX)
            r += TWO_PI_FX;
        return r[31:0];
    endfunction

    // floor square root, operand below 2^36
    function automatic longint root_floor(input longint v);
        longint r, t;
        r = 0;
        for (int b = 18; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic longint eff_accel();
        return (accel_reg == 0) ? 1 : longint'(accel_reg);
    endfunction

    function automatic longint move_length(input longint tgt, input longint pos);
        longint mag;
        mag = (tgt >= pos) ? tgt - pos : pos - tgt;
        return root_floor((4 * mag) / eff_accel());
    endfunction

    function automatic void advance_profile(input logic kind, input logic signed [31:0] tgt,
                                            input logic signed [31:0] pos);
        longint    acc, stp, d, err;
        setpoint_t res;
        acc = eff_accel();
        if (kind == KIND_GOTO) begin
            d          = longint'(tgt) - longint'(pos);
            aim_q      = pos;
            speed_q    = '0;
            elapsed_q  = '0;
            ticks_q    = 32'(move_length(longint'(tgt), longint'(pos)));
            backward_q = (d < 0);
            goal_q     = tgt;
            res.moving = 1'b1;
        end else begin
            stp = backward_q ? -acc : acc;
            if ({1'b0, elapsed_q, 1'b0} < {2'b00, ticks_q}) begin
                speed_q    = speed_q + stp[31:0];
                aim_q      = wrap_pi(longint'(aim_q) + longint'(speed_q));
                res.moving = 1'b1;
            end else if (elapsed_q < ticks_q) begin
                speed_q    = speed_q - stp[31:0];
                aim_q      = wrap_pi(longint'(aim_q) + longint'(speed_q));
                res.moving = 1'b1;
            end else begin
                speed_q    = '0;
                aim_q      = goal_q;
                res.moving = 1'b0;
            end
            if (elapsed_q != 32'hFFFF_FFFF)
                elapsed_q = elapsed_q + 1;
        end
        err = longint'(wrap_pi(longint'(goal_q) - longint'(pos)));
        if (err < 0)
            err = -err;
        res.aim       = aim_q;
        res.vel       = speed_q;
        res.at_target = (err < longint'(tol_reg));
        expected_setpoints.push_back(res);
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_profile(s_tuser[0], s_tdata[31:0], s_tdata[63:32]);
                items_taken <= items_taken + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 &&
                    ((items_taken >= CALM_LO && items_taken < CALM_HI) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    next_item = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_tdata <= {next_item.pos, next_item.tgt};
                    s_tuser <= next_item.kind;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, lets the block fill up and back-pressure its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_setpoints.size() == 0) begin
                    $error("unexpected result item, aim_angle %0d", $signed(m_tdata[31:0]));
                    errors++;
                end else begin
                    want = expected_setpoints.pop_front();
                    if (m_tdata[31:0] !== want.aim) begin
                        $error("aim_angle: expected %0d, got %0d",
                               $signed(want.aim), $signed(m_tdata[31:0]));
                        errors++;
                    end
                    if (m_tdata[63:32] !== want.vel) begin
                        $error("velocity: expected %0d, got %0d",
                               $signed(want.vel), $signed(m_tdata[63:32]));
                        errors++;
                    end
                    if (m_tdata[64] !== want.moving) begin
                        $error("moving: expected %0b, got %0b", want.moving, m_tdata[64]);
                        errors++;
                    end
                    if (m_tdata[65] !== want.at_target) begin
                        $error("at_target: expected %0b, got %0b", want.at_target, m_tdata[65]);
                        errors++;
                    end
                end
            end
            m_ready <= (hold_left == 0) &&
                       ((results_seen >= CALM_LO && results_seen < CALM_HI) ||
                        $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void add_item(input logic kind, input longint tgt, input longint pos);
        axis_item_t it;
        it.kind = kind;
        it.tgt  = tgt[31:0];
        it.pos  = pos[31:0];
        pending_items.push_back(it);
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint full_angle();
        logic signed [31:0] r;
        r = $urandom;
        return longint'(r);
    endfunction

    function automatic longint pick_angle();
        case ($urandom_range(4))
            0: return full_angle();
            1: return PI_FX - longint'($urandom_range(5000));
            2: return -PI_FX + longint'($urandom_range(5000));
            3: return longint'($urandom_range(6000)) - 3000;
            default: return longint'($urandom_range(32'(2 * TWO_PI_FX))) - TWO_PI_FX;
        endcase
    endfunction

    // encoder reading around the goal, mostly inside or just outside the arrive window
    function automatic longint pick_position(input longint goal);
        longint span;
        span = longint'(tol_reg) + 2;
        if ($urandom_range(4) == 0)
            return full_angle();
        return clamp32(goal + longint'($urandom_range(32'(2 * span))) - span);
    endfunction

    // goto followed by ticks; a broken move is cut short by whatever follows
    function automatic int add_move(input bit broken);
        longint p, d, t, n, lim;
        int     nmax, ticks;
        p    = pick_angle();
        nmax = $urandom_range(30);
        lim  = (longint'(nmax * nmax) * eff_accel()) / 4;
        d    = longint'($urandom_range(32'(lim)));
        if (broken && $urandom_range(1))
            d = longint'($urandom);
        if ($urandom_range(1))
            d = -d;
        t = p + d;
        if (t > 64'sd2147483647 || t < -64'sd2147483648)
            t = p - d;
        t = clamp32(t);
        n = move_length(t, p);
        add_item(KIND_GOTO, t, p);
        if (broken)
            ticks = $urandom_range((n > 8) ? 8 : int'(n / 2));
        else
            ticks = int'(n) + $urandom_range(1, 3);
        for (int i = 0; i < ticks; i++)
            add_item(KIND_TICK, full_angle(), pick_position(t));
        return ticks + 1;
    endfunction

    task automatic fill_phase(input int count);
        int added, sel;
        added = 0;
        while (added < count) begin
            sel = $urandom_range(9);
            if (sel < 8) begin
                added += add_move(1'b0);
            end else if (sel == 8) begin
                added += add_move(1'b1);
            end else begin
                add_item(1'($urandom_range(1)), full_angle(), full_angle());
                added++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_setpoints.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ACCEL: accel_reg = val;
            CFG_TOL:   tol_reg   = val;
            default: ;
        endcase
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // tick straight after reset snaps to zero; position extremes
        add_item(KIND_TICK, 0, 0);
        add_item(KIND_TICK, 32'sh7FFF_FFFF, 64'sd2147483647);
        add_item(KIND_TICK, -64'sd2147483648, -64'sd2147483648);
        // short forward move, six ticks long, then snap; arrive window edges
        add_item(KIND_GOTO, 144, 0);
        for (int i = 0; i < 6; i++)
            add_item(KIND_TICK, 0, longint'(144 + 100 * i));
        add_item(KIND_TICK, 0, 144 + 654);
        // largest distances both ways
        add_item(KIND_GOTO, 64'sd2147483647, -64'sd2147483648);
        add_item(KIND_TICK, -64'sd2147483648, 0);
        add_item(KIND_GOTO, -64'sd2147483648, 64'sd2147483647);
        add_item(KIND_TICK, 64'sd2147483647, -1);
        // backward move, five ticks long
        add_item(KIND_GOTO, 0, 100);
        for (int i = 0; i < 6; i++)
            add_item(KIND_TICK, 0, longint'(655 - i));

        fill_phase(100);
        wait_drained();

        // zero acceleration counts as one
        write_reg(CFG_ACCEL, 16'd0);
        write_reg(CFG_TOL, 16'hFFFF);
        fill_phase(80);
        wait_drained();

        write_reg(CFG_ACCEL, 16'hFFFF);
        write_reg(CFG_TOL, 16'd0);
        fill_phase(100);
        wait_drained();

        write_reg(CFG_IDX_SPARE, 16'h1234);
        write_reg(CFG_IDX_TOP, 16'h0001);
        write_reg(CFG_ACCEL, 16'd1000);
        write_reg(CFG_TOL, 16'd3000);
        fill_phase(70);
        wait_drained();
        fill_phase(70);
        wait_drained();

        write_reg(CFG_ACCEL, 16'($urandom_range(1, 65535)));
        write_reg(CFG_TOL, 16'($urandom_range(65535)));
        fill_phase(110);
        wait_drained();

        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_setpoints.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
